FILE: hdl/olde_pkg.sv
// ----------------------------------------------------------------------------
// olde_pkg
// Shared types and constants for the ordered list delete engine.
// ----------------------------------------------------------------------------
package olde_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 8;
    localparam int COUNT_OUT_W = 5;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_POS  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_VAL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd5;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } op_t;

    typedef struct packed {
        status_t                status;
        logic signed [31:0]     entry_out;
        logic [COUNT_OUT_W-1:0] count_out;
        logic                   last;
    } res_t;

endpackage

FILE: hdl/olde_ram.sv
// ----------------------------------------------------------------------------
// olde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/ordered_list_delete_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_delete_engine_unit
// Ordered list of signed entries held in one RAM, with append, deletes
// that close the gap, delete by value and full read-out.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  op in     start, busy, op       beat taken when start && !busy
//  result    valid, res            one-cycle strobe, no back pressure
//
//  append, delete tail, kinds six/seven and error cases: result in the cycle
//  after the beat, busy stays low.
//  delete head/position: entries above the deleted one move down a slot,
//  one RAM move a cycle, then the result.
//  delete by value: scan one entry a cycle, then the shift above.
//  read out: each entry is read from RAM, then registered out, one per cycle.
//  reset empties the list; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module ordered_list_delete_engine_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  olde_pkg::op_t     op,
    output logic              valid,
    output olde_pkg::res_t    res
);

    olde_pkg::state_t                state_reg, state_next;
    logic [olde_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [olde_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [olde_pkg::CNT_W-1:0]      ra_reg, ra_next;
    logic                            pend_reg, pend_next;
    logic [olde_pkg::DATA_W-1:0]     value_reg, value_next;
    logic                            valid_reg, valid_next;
    olde_pkg::res_t                  res_reg, res_next;

    logic                            accept;
    logic                            is_empty;
    logic                            is_full;
    logic                            pos_ok;
    logic                            reads_left;
    logic                            match;
    logic                            scan_end;
    logic                            read_last;

    logic                            wr_en;
    logic [olde_pkg::IDX_W-1:0]      wr_addr;
    logic [olde_pkg::DATA_W-1:0]     wr_data;
    logic                            rd_en;
    logic [olde_pkg::DATA_W-1:0]     rd_data;
    logic [olde_pkg::CNT_W-1:0]      ra_minus1;

    assign busy       = (state_reg != olde_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == olde_pkg::CNT_W'(olde_pkg::DEPTH));
    assign pos_ok     = (op.position != '0) &&
                        (olde_pkg::CMP_W'(op.position) <= olde_pkg::CMP_W'(count_reg));
    assign reads_left = (rd_idx_reg < count_reg);
    assign match      = pend_reg && (rd_data == value_reg);
    assign scan_end   = !reads_left && !pend_reg;
    assign read_last  = pend_reg && (ra_reg == count_reg - 1'b1);
    assign ra_minus1  = ra_reg - 1'b1;

    assign valid = valid_reg;
    assign res   = res_reg;

    olde_ram #(
        .WIDTH (olde_pkg::DATA_W),
        .DEPTH (olde_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[olde_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olde_pkg::ST_IDLE:
            begin
                if (accept && !is_empty)
                begin
                    case (op.kind)
                        olde_pkg::KIND_DEL_HEAD: state_next = olde_pkg::ST_SHIFT;
                        olde_pkg::KIND_DEL_POS:
                        begin
                            if (pos_ok)
                            begin
                                state_next = olde_pkg::ST_SHIFT;
                            end
                        end
                        olde_pkg::KIND_DEL_VAL:  state_next = olde_pkg::ST_SCAN;
                        olde_pkg::KIND_READ:     state_next = olde_pkg::ST_READ;
                        default:                 state_next = olde_pkg::ST_IDLE;
                    endcase
                end
            end
            olde_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    state_next = olde_pkg::ST_SHIFT;
                end
                else if (scan_end)
                begin
                    state_next = olde_pkg::ST_IDLE;
                end
            end
            olde_pkg::ST_SHIFT:
            begin
                if (scan_end)
                begin
                    state_next = olde_pkg::ST_IDLE;
                end
            end
            olde_pkg::ST_READ:
            begin
                if (read_last)
                begin
                    state_next = olde_pkg::ST_IDLE;
                end
            end
            default: state_next = olde_pkg::ST_IDLE;
        endcase
    end

    // datapath, ram control and result beats
    always_comb
    begin
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        ra_next     = ra_reg;
        pend_next   = 1'b0;
        value_next  = value_reg;
        valid_next  = 1'b0;
        res_next    = res_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[olde_pkg::IDX_W-1:0];
        wr_data     = op.value;
        rd_en       = 1'b0;

        case (state_reg)
            olde_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    value_next         = op.value;
                    res_next.status    = olde_pkg::STAT_DONE;
                    res_next.entry_out = '0;
                    res_next.last      = 1'b1;
                    valid_next         = 1'b1;
                    if (op.kind == olde_pkg::KIND_APPEND)
                    begin
                        if (is_full)
                        begin
                            res_next.status = olde_pkg::STAT_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (op.kind > olde_pkg::KIND_READ)
                    begin
                        res_next.status = olde_pkg::STAT_DONE;
                    end
                    else if (is_empty)
                    begin
                        res_next.status = olde_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        case (op.kind)
                            olde_pkg::KIND_DEL_TAIL:
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            olde_pkg::KIND_DEL_HEAD:
                            begin
                                valid_next  = 1'b0;
                                rd_idx_next = olde_pkg::CNT_W'(1);
                            end
                            olde_pkg::KIND_DEL_POS:
                            begin
                                if (pos_ok)
                                begin
                                    valid_next  = 1'b0;
                                    rd_idx_next = op.position[olde_pkg::CNT_W-1:0];
                                end
                                else
                                begin
                                    res_next.status = olde_pkg::STAT_NOTFOUND;
                                end
                            end
                            default:
                            begin
                                valid_next  = 1'b0;
                                rd_idx_next = '0;
                            end
                        endcase
                    end
                    res_next.count_out = olde_pkg::COUNT_OUT_W'(count_next);
                end
            end
            olde_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    rd_idx_next = ra_reg + 1'b1;
                end
                else if (scan_end)
                begin
                    valid_next         = 1'b1;
                    res_next.status    = olde_pkg::STAT_NOTFOUND;
                    res_next.entry_out = '0;
                    res_next.count_out = olde_pkg::COUNT_OUT_W'(count_reg);
                    res_next.last      = 1'b1;
                end
                else if (reads_left)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    ra_next     = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            olde_pkg::ST_SHIFT:
            begin
                // move entry ra down by one slot
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ra_minus1[olde_pkg::IDX_W-1:0];
                    wr_data = rd_data;
                end
                if (reads_left)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    ra_next     = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (scan_end)
                begin
                    count_next         = count_reg - 1'b1;
                    valid_next         = 1'b1;
                    res_next.status    = olde_pkg::STAT_DONE;
                    res_next.entry_out = '0;
                    res_next.count_out = olde_pkg::COUNT_OUT_W'(count_next);
                    res_next.last      = 1'b1;
                end
            end
            olde_pkg::ST_READ:
            begin
                if (reads_left)
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    ra_next     = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    valid_next         = 1'b1;
                    res_next.status    = olde_pkg::STAT_DONE;
                    res_next.entry_out = rd_data;
                    res_next.count_out = olde_pkg::COUNT_OUT_W'(count_reg);
                    res_next.last      = read_last;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= olde_pkg::ST_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            valid_reg  <= valid_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg    <= ra_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

endmodule
